// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the checker files.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated by the active-low reset
`define MTJ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mtj assertion failed (same cycle)");

// Next-cycle implication, gated by the active-low reset
`define MTJ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mtj assertion failed (next cycle)");

`endif

// ----- hdl/mtj_pkg.sv -----
// Shared constants and types of the mouse to joystick axis mapper.
// No dependencies; imported by every other file but assert_macros.svh.
package mtj_pkg;

    // Field widths
    localparam int ACTION_W   = 3;
    localparam int AMOUNT_W   = 16;
    localparam int AXIS_W     = 2;
    localparam int POS_W      = 16;
    localparam int WSTEP_W    = 27;
    localparam int GAIN_W     = 19;
    localparam int AMAX_W     = 15;
    localparam int AMIN_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 27;

    // Event kinds
    localparam logic [ACTION_W-1:0] ACT_X      = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_Y      = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_WHEEL  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_BUTTON = 3'd3;

    // Key state that counts as a press
    localparam logic signed [AMOUNT_W-1:0] KEY_PRESS = 16'sd1;

    // Result targets
    localparam logic [AXIS_W-1:0] AXIS_X     = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y     = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_BRAKE = 2'd2;
    localparam logic [AXIS_W-1:0] AXIS_SYNC  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_STEP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FREELOOK_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_MAX      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_MIN      = 2'd3;

    // Configuration reset values
    localparam logic [WSTEP_W-1:0]       WHEEL_STEP_RST    = 27'd6710886;
    localparam logic [GAIN_W-1:0]        FREELOOK_GAIN_RST = 19'd13107;
    localparam logic [AMAX_W-1:0]        AXIS_MAX_RST      = 15'd512;
    localparam logic signed [AMIN_W-1:0] AXIS_MIN_RST      = -16'sd512;

    // Command queued from the front end to the report sequencer
    typedef enum logic {
        CMD_AXIS = 1'b0,    // one axis value, then sync
        CMD_OFF  = 1'b1     // x zero, y zero, then sync
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [AXIS_W-1:0] axis;
    } cmd_ctl_t;

    localparam int CTL_W = $bits(cmd_ctl_t);

endpackage

// ----- hdl/mtj_in_if.sv -----
// Mouse event channel: valid/ready handshake with action and amount.
// Depends on mtj_pkg.
interface mtj_in_if
    import mtj_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action;
    logic signed [AMOUNT_W-1:0] amount;

    modport source (output valid, output action, output amount, input ready);
    modport sink   (input valid, input action, input amount, output ready);
endinterface

// ----- hdl/mtj_out_if.sv -----
// Joystick report channel: valid/ready handshake with axis, position, last.
// Depends on mtj_pkg.
interface mtj_out_if
    import mtj_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [AXIS_W-1:0]       axis;
    logic signed [POS_W-1:0] position;
    logic                    last;

    modport source (output valid, output axis, output position, output last, input ready);
    modport sink   (input valid, input axis, input position, input last, output ready);
endinterface

// ----- hdl/mouse_to_joystick_axis_mapper.sv -----
// Mouse to joystick axis mapper: top level with configuration registers,
// front end, command queue and report sequencer. Uses mtj_pkg, interfaces.
//
// Usage:
//   mouse_in (sink) takes one mouse event per transaction: action, amount.
//   joy_out (source) gives reports: axis, position, last. A wheel event or a
//   move while freelook is on yields two reports (value, sync); a button
//   press that turns freelook off yields three (x=0, y=0, sync). Other
//   events yield none. last marks the final report of an event.
//   cfg_wr_en/cfg_index/cfg_data write the four settings; write only idle.
// Timing:
//   A report passes the front end's stage 1 register, the command queue,
//   the sequencer's command register and its output register. The front
//   end takes one event per cycle while the queue has room; the report
//   sequencer sends one report per cycle while joy_out.ready is high. The
//   command queue (QUEUE_DEPTH entries) lets the front end run ahead.
// Reset: accumulators zero, freelook off, settings at defaults, no report.
// Stall: when joy_out.ready is low the report holds; the queue fills and
//   then mouse_in.ready drops until reports drain.
module mouse_to_joystick_axis_mapper
    import mtj_pkg::*;
#(
    parameter int FRAC_BITS   = 16,
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    mtj_in_if.sink                mouse_in,
    mtj_out_if.source             joy_out
);
    localparam int ACC_W = POS_W + FRAC_BITS;
    localparam int Q_W   = CTL_W + ACC_W;

    // Settings
    logic [WSTEP_W-1:0]       wheel_step_reg;
    logic [GAIN_W-1:0]        freelook_gain_reg;
    logic [AMAX_W-1:0]        axis_max_reg;
    logic signed [AMIN_W-1:0] axis_min_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheel_step_reg    <= WHEEL_STEP_RST;
            freelook_gain_reg <= FREELOOK_GAIN_RST;
            axis_max_reg      <= AXIS_MAX_RST;
            axis_min_reg      <= AXIS_MIN_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_WHEEL_STEP:    wheel_step_reg    <= cfg_data[WSTEP_W-1:0];
                CFG_FREELOOK_GAIN: freelook_gain_reg <= cfg_data[GAIN_W-1:0];
                CFG_AXIS_MAX:      axis_max_reg      <= cfg_data[AMAX_W-1:0];
                CFG_AXIS_MIN:      axis_min_reg      <= $signed(cfg_data[AMIN_W-1:0]);
                default:           wheel_step_reg    <= wheel_step_reg;
            endcase
        end
    end

    // Front end to queue
    logic                    f_valid, f_ready;
    cmd_ctl_t                f_ctl;
    logic signed [ACC_W-1:0] f_acc;

    // Queue to sequencer
    logic                    b_valid, b_ready;
    logic [Q_W-1:0]          b_data;
    cmd_ctl_t                b_ctl;
    logic signed [ACC_W-1:0] b_acc;

    mtj_front #(
        .FRAC_BITS (FRAC_BITS),
        .ACC_W     (ACC_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .mouse_in      (mouse_in),
        .wheel_step    (wheel_step_reg),
        .freelook_gain (freelook_gain_reg),
        .axis_max      (axis_max_reg),
        .axis_min      (axis_min_reg),
        .cmd_valid     (f_valid),
        .cmd_ready     (f_ready),
        .cmd_ctl       (f_ctl),
        .cmd_acc       (f_acc)
    );

    mtj_fifo #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  ({f_ctl, f_acc}),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_data)
    );

    assign b_ctl = cmd_ctl_t'(b_data[Q_W-1 -: CTL_W]);
    assign b_acc = $signed(b_data[ACC_W-1:0]);

    mtj_back #(
        .FRAC_BITS (FRAC_BITS),
        .ACC_W     (ACC_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (b_valid),
        .cmd_ready (b_ready),
        .cmd_ctl   (b_ctl),
        .cmd_acc   (b_acc),
        .joy_out   (joy_out)
    );

endmodule

// ----- hdl/mtj_fifo.sv -----
// Small flop-based command queue between front end and report sequencer.
// Depends on mtj_pkg only by convention; generic width and depth.
module mtj_fifo
    import mtj_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer wrap and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- hdl/mtj_front.sv -----
// Front end: accepts mouse events, scales deltas, updates the clamped
// accumulators and freelook state, and queues report commands. Uses mtj_pkg.
module mtj_front
    import mtj_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int ACC_W     = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    mtj_in_if.sink                   mouse_in,
    input  logic [WSTEP_W-1:0]       wheel_step,
    input  logic [GAIN_W-1:0]        freelook_gain,
    input  logic [AMAX_W-1:0]        axis_max,
    input  logic signed [AMIN_W-1:0] axis_min,
    output logic                     cmd_valid,
    input  logic                     cmd_ready,
    output cmd_ctl_t                 cmd_ctl,
    output logic signed [ACC_W-1:0]  cmd_acc
);
    localparam int PROD_W = AMOUNT_W + WSTEP_W + 1;
    localparam int SUM_W  = ((ACC_W > PROD_W) ? ACC_W : PROD_W) + 1;

    // Stage 1: registered event and scaled delta
    logic                      s1_valid_reg;
    logic [ACTION_W-1:0]       s1_action_reg;
    logic                      s1_press_reg;
    logic signed [PROD_W-1:0]  s1_prod_reg;
    logic [WSTEP_W-1:0]        mult_op;
    logic signed [PROD_W-1:0]  prod;
    logic                      s1_adv;

    // Accumulator state
    logic signed [ACC_W-1:0] pedal_acc_reg, pedal_acc_next;
    logic signed [ACC_W-1:0] look_x_acc_reg, look_x_acc_next;
    logic signed [ACC_W-1:0] look_y_acc_reg, look_y_acc_next;
    logic                    look_on_reg, look_on_next;

    // Stage 2 datapath
    logic signed [ACC_W-1:0] acc_cur, acc_new, lim_hi, lim_lo;
    logic signed [SUM_W-1:0] sum_w, hi_w, lo_w, clamp_w;
    logic                    do_push;

    assign mouse_in.ready = !s1_valid_reg || cmd_ready;
    assign s1_adv         = s1_valid_reg && cmd_ready;

    // Scale factor: wheel step for the pedal, freelook gain for moves
    assign mult_op = (mouse_in.action == ACT_WHEEL) ? wheel_step : WSTEP_W'(freelook_gain);
    assign prod    = PROD_W'(mouse_in.amount * $signed({1'b0, mult_op}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (mouse_in.ready)
        begin
            s1_valid_reg <= mouse_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mouse_in.valid && mouse_in.ready)
        begin
            s1_action_reg <= mouse_in.action;
            s1_press_reg  <= (mouse_in.amount == KEY_PRESS);
            s1_prod_reg   <= prod;
        end
    end

    // Pick the accumulator that this event touches
    always_comb
    begin
        unique case (s1_action_reg)
            ACT_WHEEL: acc_cur = pedal_acc_reg;
            ACT_Y:     acc_cur = look_y_acc_reg;
            default:   acc_cur = look_x_acc_reg;
        endcase
    end

    // Add and clamp: upper limit first, so crossed limits give the lower one
    assign lim_hi  = {1'b0, axis_max, {FRAC_BITS{1'b0}}};
    assign lim_lo  = {axis_min, {FRAC_BITS{1'b0}}};
    assign hi_w    = SUM_W'(lim_hi);
    assign lo_w    = SUM_W'(lim_lo);
    assign sum_w   = SUM_W'(acc_cur) + SUM_W'(s1_prod_reg);
    assign clamp_w = (sum_w > hi_w) ? ((hi_w < lo_w) ? lo_w : hi_w)
                                    : ((sum_w < lo_w) ? lo_w : sum_w);
    assign acc_new = clamp_w[ACC_W-1:0];

    // Classify and decide state updates and the queued command
    always_comb
    begin
        do_push         = 1'b0;
        cmd_ctl.kind    = CMD_AXIS;
        cmd_ctl.axis    = AXIS_BRAKE;
        cmd_acc         = acc_new;
        pedal_acc_next  = pedal_acc_reg;
        look_x_acc_next = look_x_acc_reg;
        look_y_acc_next = look_y_acc_reg;
        look_on_next    = look_on_reg;
        unique case (s1_action_reg)
            ACT_WHEEL:
            begin
                do_push        = 1'b1;
                pedal_acc_next = acc_new;
            end
            ACT_X:
            begin
                if (look_on_reg)
                begin
                    do_push         = 1'b1;
                    cmd_ctl.axis    = AXIS_X;
                    look_x_acc_next = acc_new;
                end
            end
            ACT_Y:
            begin
                if (look_on_reg)
                begin
                    do_push         = 1'b1;
                    cmd_ctl.axis    = AXIS_Y;
                    look_y_acc_next = acc_new;
                end
            end
            ACT_BUTTON:
            begin
                if (s1_press_reg)
                begin
                    look_on_next = !look_on_reg;
                    if (look_on_reg)
                    begin
                        // freelook off: recenter both look axes
                        do_push         = 1'b1;
                        cmd_ctl.kind    = CMD_OFF;
                        cmd_ctl.axis    = AXIS_X;
                        cmd_acc         = '0;
                        look_x_acc_next = '0;
                        look_y_acc_next = '0;
                    end
                end
            end
            default:
            begin
                do_push = 1'b0;
            end
        endcase
    end

    assign cmd_valid = s1_valid_reg && do_push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pedal_acc_reg  <= '0;
            look_x_acc_reg <= '0;
            look_y_acc_reg <= '0;
            look_on_reg    <= 1'b0;
        end
        else if (s1_adv)
        begin
            pedal_acc_reg  <= pedal_acc_next;
            look_x_acc_reg <= look_x_acc_next;
            look_y_acc_reg <= look_y_acc_next;
            look_on_reg    <= look_on_next;
        end
    end

endmodule

// ----- hdl/mtj_back.sv -----
// Report sequencer: takes queued commands, rounds their values, emits one
// report per cycle via an output register when not stalled. Uses mtj_pkg.
module mtj_back
    import mtj_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int ACC_W     = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cmd_valid,
    output logic                    cmd_ready,
    input  cmd_ctl_t                cmd_ctl,
    input  logic signed [ACC_W-1:0] cmd_acc,
    mtj_out_if.source               joy_out
);
    localparam logic [ACC_W:0] HALF = (ACC_W + 1)'(1) << (FRAC_BITS - 1);

    localparam logic [1:0] BEAT_FIRST  = 2'd0;
    localparam logic [1:0] BEAT_SECOND = 2'd1;
    localparam logic [1:0] BEAT_THIRD  = 2'd2;

    // Command being played out
    logic                    cur_valid_reg;
    cmd_ctl_t                cur_ctl_reg;
    logic signed [ACC_W-1:0] cur_acc_reg;
    logic [1:0]              beat_reg, beat_next;

    // Output register
    logic                    out_valid_reg;
    logic [AXIS_W-1:0]       out_axis_reg;
    logic signed [POS_W-1:0] out_pos_reg;
    logic                    out_last_reg;

    logic                    out_free, emit, beat_is_last;
    logic [AXIS_W-1:0]       beat_axis;
    logic signed [POS_W-1:0] beat_pos;
    logic signed [ACC_W:0]   rnd_sum;
    logic [ACC_W:0]          rnd_bias;

    assign out_free     = !out_valid_reg || joy_out.ready;
    assign emit         = cur_valid_reg && out_free;
    assign beat_is_last = (cur_ctl_reg.kind == CMD_OFF) ? (beat_reg == BEAT_THIRD)
                                                        : (beat_reg == BEAT_SECOND);
    assign cmd_ready    = !cur_valid_reg || (emit && beat_is_last);
    assign beat_next    = beat_is_last ? BEAT_FIRST : beat_reg + 1'b1;

    // Round half away from zero: bias by half, one less when negative
    assign rnd_bias = cur_acc_reg[ACC_W-1] ? HALF - 1'b1 : HALF;
    assign rnd_sum  = $signed({cur_acc_reg[ACC_W-1], cur_acc_reg}) + $signed(rnd_bias);

    // Report fields of the current beat
    always_comb
    begin
        unique case (beat_reg)
            BEAT_FIRST:
            begin
                beat_axis = cur_ctl_reg.axis;
                beat_pos  = rnd_sum[FRAC_BITS +: POS_W];
            end
            BEAT_SECOND:
            begin
                beat_axis = (cur_ctl_reg.kind == CMD_OFF) ? AXIS_Y : AXIS_SYNC;
                beat_pos  = '0;
            end
            default:
            begin
                beat_axis = AXIS_SYNC;
                beat_pos  = '0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            beat_reg      <= BEAT_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_ready)
            begin
                cur_valid_reg <= cmd_valid;
            end
            if (emit)
            begin
                beat_reg <= beat_next;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (joy_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_ready && cmd_valid)
        begin
            cur_ctl_reg <= cmd_ctl;
            cur_acc_reg <= cmd_acc;
        end
        if (emit)
        begin
            out_axis_reg <= beat_axis;
            out_pos_reg  <= beat_pos;
            out_last_reg <= beat_is_last;
        end
    end

    assign joy_out.valid    = out_valid_reg;
    assign joy_out.axis     = out_axis_reg;
    assign joy_out.position = out_pos_reg;
    assign joy_out.last     = out_last_reg;

endmodule

// ----- hdl/mtj_checker.sv -----
// Port-level checker for the axis mapper's report channel, and its bind.
// Depends on mtj_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mtj_checker
    import mtj_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic [AXIS_W-1:0]       out_axis,
    input logic signed [POS_W-1:0] out_position,
    input logic                    out_last
);
    localparam int RPT_W = AXIS_W + POS_W + 1;

    // Report channel views
    logic             rpt_sync;
    logic             brake_taken;
    logic             stalled;
    logic [RPT_W-1:0] rpt_word;

    assign rpt_sync    = out_valid && (out_axis == AXIS_SYNC);
    assign brake_taken = out_valid && out_ready && (out_axis == AXIS_BRAKE);
    assign stalled     = out_valid && !out_ready;
    assign rpt_word    = {out_axis, out_position, out_last};

    // Sync reports carry no position
    `MTJ_ASSERT_NOW(a_sync_zero, clk, rst_n, rpt_sync, out_position == '0)

    // The final report of an event is always the sync report, and only it
    `MTJ_ASSERT_NOW(a_last_is_sync, clk, rst_n, out_valid, out_last == (out_axis == AXIS_SYNC))

    // A taken brake report is followed at once by its sync
    `MTJ_ASSERT_NEXT(a_brake_sync, clk, rst_n, brake_taken, rpt_sync)

    // A stalled report holds
    `MTJ_ASSERT_NEXT(a_stall_hold, clk, rst_n, stalled, out_valid && $stable(rpt_word))

endmodule

bind mouse_to_joystick_axis_mapper mtj_checker u_mtj_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (joy_out.valid),
    .out_ready    (joy_out.ready),
    .out_axis     (joy_out.axis),
    .out_position (joy_out.position),
    .out_last     (joy_out.last)
);

// ----- verif/mtj_tb_pkg.sv -----
`timescale 1ns / 1ps
// Report scoreboard for the mouse to joystick axis mapper testbench.
// Holds the predicted settings, accumulators and queued reports; uses mtj_pkg.
package mtj_tb_pkg;
    import mtj_pkg::*;

    // Fraction bits of every accumulator; the block is built with the same value
    localparam int FRAC = 16;

    typedef struct {
        logic [AXIS_W-1:0]       axis;
        logic signed [POS_W-1:0] position;
        logic                    last;
    } joy_report_t;

    class joy_report_scoreboard;
        int unsigned wheel_step;
        int unsigned look_gain;
        int          axis_hi;
        int          axis_lo;
        longint      pedal_acc;
        longint      look_x_acc;
        longint      look_y_acc;
        bit          look_on;
        joy_report_t reports_due[$];
        int unsigned fail_count;

        function new();
            wheel_step = 32'(WHEEL_STEP_RST);
            look_gain  = 32'(FREELOOK_GAIN_RST);
            axis_hi    = 32'(AXIS_MAX_RST);
            axis_lo    = 32'(AXIS_MIN_RST);
            pedal_acc  = 0;
            look_x_acc = 0;
            look_y_acc = 0;
            look_on    = 1'b0;
            fail_count = 0;
        endfunction

        function int pending();
            return reports_due.size();
        endfunction

        // Register write, applied while the block is idle
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_WHEEL_STEP:    wheel_step = 32'(data[WSTEP_W-1:0]);
                CFG_FREELOOK_GAIN: look_gain  = 32'(data[GAIN_W-1:0]);
                CFG_AXIS_MAX:      axis_hi    = 32'(data[AMAX_W-1:0]);
                CFG_AXIS_MIN:      axis_lo    = 32'($signed(data[AMIN_W-1:0]));
                default: ;
            endcase
        endfunction

        // Upper limit first, then lower: crossed limits end at the lower one
        function longint clamp_acc(longint v);
            longint one;
            one = longint'(1) << FRAC;
            if (v > longint'(axis_hi) * one)
                v = longint'(axis_hi) * one;
            if (v < longint'(axis_lo) * one)
                v = longint'(axis_lo) * one;
            return v;
        endfunction

        // Round half away from zero
        function longint round_pos(longint v);
            longint half;
            half = longint'(1) << (FRAC - 1);
            if (v >= 0)
                return (v + half) >>> FRAC;
            return -((-v + half) >>> FRAC);
        endfunction

        function void push_report(logic [AXIS_W-1:0] axis, longint v, logic last);
            joy_report_t r;
            r.axis     = axis;
            r.position = v[POS_W-1:0];
            r.last     = last;
            reports_due.push_back(r);
        endfunction

        // Accepted mouse event: update state and queue the reports it causes
        function void note_event(logic [ACTION_W-1:0] action, logic signed [AMOUNT_W-1:0] amount);
            longint delta;
            case (action)
                ACT_WHEEL:
                begin
                    pedal_acc = clamp_acc(pedal_acc + longint'(amount) * longint'(wheel_step));
                    push_report(AXIS_BRAKE, round_pos(pedal_acc), 1'b0);
                    push_report(AXIS_SYNC, 0, 1'b1);
                end
                ACT_X, ACT_Y:
                begin
                    if (look_on)
                    begin
                        delta = longint'(amount) * longint'(look_gain);
                        if (action == ACT_X)
                        begin
                            look_x_acc = clamp_acc(look_x_acc + delta);
                            push_report(AXIS_X, round_pos(look_x_acc), 1'b0);
                        end
                        else
                        begin
                            look_y_acc = clamp_acc(look_y_acc + delta);
                            push_report(AXIS_Y, round_pos(look_y_acc), 1'b0);
                        end
                        push_report(AXIS_SYNC, 0, 1'b1);
                    end
                end
                ACT_BUTTON:
                begin
                    if (amount == KEY_PRESS)
                    begin
                        look_on = !look_on;
                        if (!look_on)
                        begin
                            look_x_acc = 0;
                            look_y_acc = 0;
                            push_report(AXIS_X, 0, 1'b0);
                            push_report(AXIS_Y, 0, 1'b0);
                            push_report(AXIS_SYNC, 0, 1'b1);
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        // Accepted report: compare with the oldest prediction
        function void check_report(logic [AXIS_W-1:0] axis, logic signed [POS_W-1:0] position,
                                   logic last);
            joy_report_t exp_r;
            if (reports_due.size() == 0)
            begin
                $error("unexpected report: axis %0d position %0d last %0b", axis, position, last);
                fail_count++;
                return;
            end
            exp_r = reports_due.pop_front();
            if (axis !== exp_r.axis)
            begin
                $error("axis mismatch: expected %0d, got %0d", exp_r.axis, axis);
                fail_count++;
            end
            if (position !== exp_r.position)
            begin
                $error("position mismatch: expected %0d, got %0d", exp_r.position, position);
                fail_count++;
            end
            if (last !== exp_r.last)
            begin
                $error("last mismatch: expected %0b, got %0b", exp_r.last, last);
                fail_count++;
            end
        endfunction
    endclass

endpackage

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// Top-level testbench of the mouse to joystick axis mapper.
// Depends on mtj_pkg, mtj_in_if, mtj_out_if, mtj_tb_pkg and the block itself.
module tb_top;
    import mtj_pkg::*;
    import mtj_tb_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 12;
    localparam logic [ACTION_W-1:0] ACT_SPARE_LO = ACT_BUTTON + 3'd1;
    localparam logic [ACTION_W-1:0] ACT_SPARE_HI = '1;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    idle_pct;
    int                    stall_pct;
    int unsigned           cycle_count = 0;
    joy_report_scoreboard  sb;

    mtj_in_if  mouse ();
    mtj_out_if joy ();

    mouse_to_joystick_axis_mapper #(.FRAC_BITS(FRAC)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mouse_in  (mouse),
        .joy_out   (joy)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver back-pressure
    always @(posedge clk)
        joy.ready <= ($urandom_range(99) >= stall_pct);

    // Monitors: predict on each accepted event, check each accepted report
    always @(posedge clk)
    begin
        if (rst_n && mouse.valid && mouse.ready)
            sb.note_event(mouse.action, mouse.amount);
        if (rst_n && joy.valid && joy.ready)
            sb.check_report(joy.axis, joy.position, joy.last);
    end

    // One mouse transaction, with random gaps ahead of it
    task automatic send_event(input logic [ACTION_W-1:0] act, input logic signed [AMOUNT_W-1:0] amt);
        while ($urandom_range(99) < idle_pct)
        begin
            mouse.valid <= 1'b0;
            @(posedge clk);
        end
        mouse.valid  <= 1'b1;
        mouse.action <= act;
        mouse.amount <= amt;
        do @(posedge clk); while (!mouse.ready);
    endtask

    // Stop sending, wait for every predicted report, then let the block settle
    task automatic wait_reports_drained();
        mouse.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all four settings on consecutive cycles; block must be idle
    task automatic program_settings(input int ws, input int gain, input int amax, input int amin);
        logic [CFG_IDX_W-1:0]  regs [4];
        logic [CFG_DATA_W-1:0] vals [4];
        regs = '{CFG_WHEEL_STEP, CFG_FREELOOK_GAIN, CFG_AXIS_MAX, CFG_AXIS_MIN};
        vals[0] = CFG_DATA_W'(ws);
        vals[1] = CFG_DATA_W'(gain);
        vals[2] = CFG_DATA_W'(amax);
        vals[3] = CFG_DATA_W'(amin);
        for (int i = 0; i < 4; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            sb.write_reg(regs[i], vals[i]);
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Delta mix: mostly small and medium steps, some full-range
    function automatic logic signed [AMOUNT_W-1:0] pick_delta();
        int unsigned mode;
        int v;
        mode = $urandom_range(99);
        if (mode < 40)
            v = int'($urandom_range(16)) - 8;
        else if (mode < 70)
            v = int'($urandom_range(600)) - 300;
        else
            v = $urandom_range(65535);
        return v[AMOUNT_W-1:0];
    endfunction

    task automatic pick_event(output logic [ACTION_W-1:0] act,
                              output logic signed [AMOUNT_W-1:0] amt);
        int unsigned r;
        r = $urandom_range(99);
        amt = pick_delta();
        if (r < 25)
            act = ACT_WHEEL;
        else if (r < 47)
            act = ACT_X;
        else if (r < 69)
            act = ACT_Y;
        else if (r < 81)
        begin
            act = ACT_BUTTON;
            amt = KEY_PRESS;
        end
        else if (r < 88)
        begin
            // release, repeat or any other key state
            act = ACT_BUTTON;
            amt = AMOUNT_W'($urandom_range(65535));
            if (amt == KEY_PRESS)
                amt = '0;
        end
        else
            act = ACT_BUTTON + ACTION_W'($urandom_range(4, 1));
    endtask

    task automatic run_random(input int count);
        logic [ACTION_W-1:0]        act;
        logic signed [AMOUNT_W-1:0] amt;
        for (int i = 0; i < count; i++)
        begin
            pick_event(act, amt);
            send_event(act, amt);
            // occasional full drain so the block runs dry mid-phase
            if ($urandom_range(29) == 0)
                wait_reports_drained();
        end
    endtask

    initial
    begin
        sb = new();
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        mouse.valid  = 1'b0;
        mouse.action = '0;
        mouse.amount = '0;
        joy.ready    = 1'b0;
        idle_pct     = 0;
        stall_pct    = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, no idling
        send_event(ACT_SPARE_LO, 16'sh7FFF);     // ignored actions
        send_event(ACT_SPARE_HI, -16'sd1);
        send_event(ACT_SPARE_LO + 3'd1, 16'sh8000);
        send_event(ACT_SPARE_HI - 3'd1, 16'sd0);
        send_event(ACT_X, 16'sd100);             // moves with freelook off
        send_event(ACT_Y, -16'sd100);
        send_event(ACT_BUTTON, 16'sd0);          // release and other key states
        send_event(ACT_BUTTON, 16'sd2);
        send_event(ACT_BUTTON, -16'sd1);
        send_event(ACT_WHEEL, 16'sd1);
        send_event(ACT_WHEEL, -16'sd1);
        send_event(ACT_WHEEL, 16'sd0);
        send_event(ACT_WHEEL, 16'sd32767);       // clamp at the upper limit
        send_event(ACT_WHEEL, -16'sd32768);      // clamp at the lower limit
        send_event(ACT_WHEEL, 16'sd3);
        send_event(ACT_BUTTON, KEY_PRESS);       // freelook on, no report
        send_event(ACT_X, 16'sd32767);
        send_event(ACT_Y, -16'sd32768);
        send_event(ACT_X, -16'sd5);
        send_event(ACT_Y, 16'sd7);
        send_event(ACT_WHEEL, 16'sd2);           // wheel while freelook on
        send_event(ACT_X, 16'sd0);
        send_event(ACT_BUTTON, KEY_PRESS);       // freelook off: x, y, sync
        send_event(ACT_X, 16'sd10);
        run_random(30);
        wait_reports_drained();

        // Half-unit gains so that rounding ties come up; sender idling
        program_settings(98304, 32768, 1000, -1000);
        idle_pct = 65;
        run_random(45);
        wait_reports_drained();

        // Widest limits, large gains; receiver stalling
        program_settings(67108864, 262144, 32767, -32768);
        idle_pct  = 0;
        stall_pct = 65;
        run_random(45);
        wait_reports_drained();

        // Zero gains and zero limits; both sides idling a little
        program_settings(0, 0, 0, 0);
        idle_pct  = 10;
        stall_pct = 10;
        run_random(25);
        wait_reports_drained();

        // Crossed limits: everything ends at the lower limit
        program_settings(65536, 65536, 100, 200);
        idle_pct  = 0;
        stall_pct = 0;
        run_random(25);
        wait_reports_drained();

        // Random settings; both sides idling hard
        program_settings($urandom_range(67108864), $urandom_range(262144),
                         $urandom_range(32767), -int'($urandom_range(32768)));
        idle_pct  = 65;
        stall_pct = 65;
        run_random(50);
        wait_reports_drained();

        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
